[hw/rtl/s2sa_pkg.sv]
// package for the spin to spherical angles core
// shared constants, queue entry type and the cordic angle table; no dependencies
`timescale 1ns / 1ps

package s2sa_pkg;

  // cordic iteration count, limited by the length of the angle table
  localparam int CORDIC_STEPS  = 16;
  localparam int ANG_TABLE_LEN = 24;
  localparam int STEPS_EFF     = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_STEPS;
  localparam int STEP_W        = $clog2(ANG_TABLE_LEN + 1);

  // datapath widths
  localparam int MAG_W   = 16;   // component magnitude, 0..32768
  localparam int PRE_SH  = 14;   // prescale of magnitudes before the passes
  localparam int CW      = 33;   // cordic x / y width, signed
  localparam int ACC_W   = 25;   // angle accumulator, signed, 1/65536 degree
  localparam int TAB_W   = 22;   // widest table entry
  localparam int ANG_W   = 14;   // pass angle in 1/128 degree, 0..11520
  localparam int PHI_W   = 16;   // azimuth in 1/128 degree, 0..46079
  localparam int AZ_W    = 17;
  localparam int EL_W    = 15;
  localparam int LEN_W   = 31;   // useful bits of the gained length
  localparam int R_W     = 31;

  // gain removal, 1/K in Q30
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam int          GAIN_SH      = 30;

  localparam int QUARTER_FINE = 5898240;
  localparam int QUARTER_128  = 11520;
  localparam int HALF_128     = 23040;
  localparam int FULL_128     = 46080;

  // one classified vector, as it waits between front and back
  typedef struct packed {
    logic             zero;
    logic             neg_x;
    logic             neg_y;
    logic             neg_z;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] mag_z;
  } s2sa_item_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  function automatic logic [TAB_W-1:0] atan_fine(input logic [STEP_W-1:0] i);
    logic [TAB_W-1:0] v;
    unique case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/s2sa_front.sv]
// front end: classifies an incoming spin vector and takes component magnitudes
// depends on s2sa_pkg
`timescale 1ns / 1ps

module s2sa_front (
  input  logic signed [15:0] spin_x,
  input  logic signed [15:0] spin_y,
  input  logic signed [15:0] spin_z,
  output s2sa_pkg::s2sa_item_t item
);

  always_comb begin
    item.zero  = (spin_x == 16'sd0) || (spin_y == 16'sd0) || (spin_z == 16'sd0);
    item.neg_x = spin_x[15];
    item.neg_y = spin_y[15];
    item.neg_z = spin_z[15];
    // most negative input gives 32768, still fits unsigned
    item.mag_x = spin_x[15] ? 16'(-spin_x) : 16'(spin_x);
    item.mag_y = spin_y[15] ? 16'(-spin_y) : 16'(spin_y);
    item.mag_z = spin_z[15] ? 16'(-spin_z) : 16'(spin_z);
  end

endmodule

[hw/rtl/s2sa_queue.sv]
// two-entry queue of classified vectors between front and back
// depends on s2sa_pkg
`timescale 1ns / 1ps

module s2sa_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  s2sa_pkg::s2sa_item_t wr_item,
  input  logic                 rd_en,
  output s2sa_pkg::s2sa_item_t rd_item,
  output logic                 q_full,
  output logic                 q_empty
);

  s2sa_pkg::s2sa_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/s2sa_cordic.sv]
// shared vectoring cordic unit, one micro-rotation per cycle
// depends on s2sa_pkg
`timescale 1ns / 1ps

module s2sa_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [s2sa_pkg::CW-1:0]      x_init,
  input  logic signed [s2sa_pkg::CW-1:0]      y_init,
  output logic                                done,
  output logic signed [s2sa_pkg::CW-1:0]      len,
  output logic        [s2sa_pkg::ANG_W-1:0]   angle
);

  logic signed [s2sa_pkg::CW-1:0]    x;
  logic signed [s2sa_pkg::CW-1:0]    y;
  logic signed [s2sa_pkg::ACC_W-1:0] acc;
  logic        [s2sa_pkg::STEP_W-1:0] idx;
  logic                              busy;

  logic signed [s2sa_pkg::CW-1:0]    dx;
  logic signed [s2sa_pkg::CW-1:0]    dy;
  logic signed [s2sa_pkg::ACC_W-1:0] step_ang;
  logic        [22:0]                acc_clamp;
  logic        [22:0]                acc_round;
  logic                              last_step;

  assign dx        = y >>> idx;
  assign dy        = x >>> idx;
  assign step_ang  = s2sa_pkg::ACC_W'({1'b0, s2sa_pkg::atan_fine(idx)});
  assign len       = x;
  assign last_step = (idx == s2sa_pkg::STEP_W'(s2sa_pkg::STEPS_EFF - 1));

  // clamp to a quarter turn, then round to 1/128 degree
  always_comb begin
    if (acc < 0) begin
      acc_clamp = 23'd0;
    end else if (acc > s2sa_pkg::ACC_W'(s2sa_pkg::QUARTER_FINE)) begin
      acc_clamp = 23'(s2sa_pkg::QUARTER_FINE);
    end else begin
      acc_clamp = acc[22:0];
    end
    acc_round = acc_clamp + 23'd256;
    angle     = acc_round[22:9];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && last_step;
      if (start) begin
        x    <= x_init;
        y    <= y_init;
        acc  <= '0;
        idx  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!y[s2sa_pkg::CW-1]) begin
          x   <= x + dx;
          y   <= y - dy;
          acc <= acc + step_ang;
        end else begin
          x   <= x - dx;
          y   <= y + dy;
          acc <= acc - step_ang;
        end
        idx <= idx + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[hw/rtl/s2sa_back.sv]
// back end: sequences the two cordic passes, gain removal, quadrant fold,
// held angles and the result register; depends on s2sa_pkg and s2sa_cordic
`timescale 1ns / 1ps

module s2sa_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  s2sa_pkg::s2sa_item_t                 q_item,
  output logic                                 q_pop,
  input  logic                                 pop,
  output logic                                 out_valid,
  output logic signed [s2sa_pkg::AZ_W-1:0]     cone_azimuth,
  output logic signed [s2sa_pkg::EL_W-1:0]     cone_elevation,
  output logic                                 unhandled
);

  typedef enum logic [2:0] {
    S_IDLE, S_PASS1, S_MUL_LO, S_MUL_HI, S_ROUND, S_PASS2, S_RESULT
  } state_t;

  state_t state;

  s2sa_pkg::s2sa_item_t                item;
  logic                                cord_start;
  logic                                cord_start_next;
  logic signed [s2sa_pkg::CW-1:0]      cord_x;
  logic signed [s2sa_pkg::CW-1:0]      cord_y;
  logic                                cord_done;
  logic signed [s2sa_pkg::CW-1:0]      cord_len;
  logic        [s2sa_pkg::ANG_W-1:0]   cord_angle;
  logic                                load_result;

  logic        [s2sa_pkg::LEN_W-1:0]   len;
  logic        [45:0]                  prod_lo;
  logic        [44:0]                  prod_hi;
  logic        [61:0]                  gain_sum;
  logic        [s2sa_pkg::R_W-1:0]     r_next;
  logic        [s2sa_pkg::PHI_W-1:0]   phi_next;
  logic        [s2sa_pkg::ANG_W-1:0]   t_clamp;
  logic signed [s2sa_pkg::AZ_W-1:0]    azimuth;
  logic signed [s2sa_pkg::EL_W-1:0]    elevation_next;
  logic signed [s2sa_pkg::EL_W-1:0]    elevation;
  logic signed [s2sa_pkg::AZ_W-1:0]    held_azimuth;
  logic signed [s2sa_pkg::EL_W-1:0]    held_elevation;

  s2sa_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cord_start),
    .x_init (cord_x),
    .y_init (cord_y),
    .done   (cord_done),
    .len    (cord_len),
    .angle  (cord_angle)
  );

  assign q_pop = (state == S_IDLE) && !q_empty;

  // a pass starts after pulling a vector with no zero component, and after rounding
  assign cord_start_next = (q_pop && !q_item.zero) || (state == S_ROUND);

  // result register loads when free or when its transfer happens this edge
  assign load_result = (state == S_RESULT) && (!out_valid || pop);

  // quadrant fold of the first-quadrant angle
  always_comb begin
    priority if (!item.neg_x && !item.neg_y) begin
      phi_next = s2sa_pkg::PHI_W'(cord_angle);
    end else if (item.neg_x && !item.neg_y) begin
      phi_next = s2sa_pkg::PHI_W'(s2sa_pkg::HALF_128) - s2sa_pkg::PHI_W'(cord_angle);
    end else if (item.neg_x) begin
      phi_next = s2sa_pkg::PHI_W'(s2sa_pkg::HALF_128) + s2sa_pkg::PHI_W'(cord_angle);
    end else begin
      phi_next = s2sa_pkg::PHI_W'(s2sa_pkg::FULL_128) - s2sa_pkg::PHI_W'(cord_angle);
    end
    if (phi_next >= s2sa_pkg::PHI_W'(s2sa_pkg::FULL_128)) begin
      phi_next = phi_next - s2sa_pkg::PHI_W'(s2sa_pkg::FULL_128);
    end
  end

  // gain removal, half up, floor of one
  always_comb begin
    gain_sum = 62'({prod_hi, 16'd0}) + 62'(prod_lo) + (62'd1 << (s2sa_pkg::GAIN_SH - 1));
    r_next   = gain_sum[60:30];
    if (r_next == '0) begin
      r_next = s2sa_pkg::R_W'(1);
    end
  end

  // elevation sign follows z, negated for the cone
  always_comb begin
    t_clamp = (cord_angle > s2sa_pkg::ANG_W'(s2sa_pkg::QUARTER_128)) ?
              s2sa_pkg::ANG_W'(s2sa_pkg::QUARTER_128) : cord_angle;
    elevation_next = item.neg_z ? $signed({1'b0, t_clamp}) : -$signed({1'b0, t_clamp});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cord_start     <= 1'b0;
      out_valid      <= 1'b0;
      held_azimuth   <= '0;
      held_elevation <= '0;
    end else begin
      cord_start <= cord_start_next;
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            item <= q_item;
            if (q_item.zero) begin
              state <= S_RESULT;
            end else begin
              cord_x <= s2sa_pkg::CW'(q_item.mag_x) << s2sa_pkg::PRE_SH;
              cord_y <= s2sa_pkg::CW'(q_item.mag_y) << s2sa_pkg::PRE_SH;
              state  <= S_PASS1;
            end
          end
        end
        S_PASS1: begin
          if (cord_done) begin
            len     <= cord_len[s2sa_pkg::LEN_W-1:0];
            azimuth <= -$signed({1'b0, phi_next});
            state   <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          prod_lo <= 46'(len[15:0]) * 46'(s2sa_pkg::INV_GAIN_Q30);
          state   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_hi <= 45'(len[30:16]) * 45'(s2sa_pkg::INV_GAIN_Q30);
          state   <= S_ROUND;
        end
        S_ROUND: begin
          cord_x <= s2sa_pkg::CW'(r_next);
          cord_y <= s2sa_pkg::CW'(item.mag_z) << s2sa_pkg::PRE_SH;
          state  <= S_PASS2;
        end
        S_PASS2: begin
          if (cord_done) begin
            elevation <= elevation_next;
            state     <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (load_result) begin
            unhandled <= item.zero;
            if (item.zero) begin
              cone_azimuth   <= held_azimuth;
              cone_elevation <= held_elevation;
            end else begin
              cone_azimuth   <= azimuth;
              cone_elevation <= elevation;
              held_azimuth   <= azimuth;
              held_elevation <= elevation;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/spin_to_spherical_angles_core.sv]
// top level of the spin to spherical angles core
// holds front, queue and back; depends on s2sa_pkg, s2sa_front, s2sa_queue, s2sa_back
`timescale 1ns / 1ps

// channel  | handshake      | payload
// ---------+----------------+------------------------------------------------
// input    | push / full    | spin_x, spin_y, spin_z (signed q1.15)
// result   | empty / pop    | cone_azimuth, cone_elevation, unhandled
//
// a vector with all components nonzero goes through two passes of the shared
// cordic unit, one micro-rotation a cycle, with the gain removal between the
// passes; a vector with a zero component skips the passes. the two-entry queue
// takes transfers while the back is busy or a result waits. synchronous reset
// empties the queue and result register and clears the held angles to zero.

module spin_to_spherical_angles_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [15:0]                   spin_x,
  input  logic signed [15:0]                   spin_y,
  input  logic signed [15:0]                   spin_z,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [s2sa_pkg::AZ_W-1:0]     cone_azimuth,
  output logic signed [s2sa_pkg::EL_W-1:0]     cone_elevation,
  output logic                                 unhandled
);

  s2sa_pkg::s2sa_item_t front_item;   // classified vector from the front
  s2sa_pkg::s2sa_item_t q_item;       // oldest waiting vector
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  logic                 out_valid;

  // input transfer straight into the queue
  assign full  = q_full;
  assign empty = !out_valid;

  s2sa_front u_front (
    .spin_x (spin_x),
    .spin_y (spin_y),
    .spin_z (spin_z),
    .item   (front_item)
  );

  s2sa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !q_full),
    .wr_item (front_item),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // back pulls a vector only when idle, so its pace sets the queue drain
  s2sa_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .pop            (pop),
    .out_valid      (out_valid),
    .cone_azimuth   (cone_azimuth),
    .cone_elevation (cone_elevation),
    .unhandled      (unhandled)
  );

`ifndef SYNTH
  // queue can never be full and empty at once
  a_queue_sane: assert property (@(posedge clk) disable iff (rst) !(q_full && q_empty))
    else $error("queue reports full and empty together");

  // back only pulls from a queue that holds something
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("back pulled from an empty queue");

  // azimuth stays in a single turn, negated
  a_azimuth_range: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (cone_azimuth <= 17'sd0 && cone_azimuth > -17'sd46080))
    else $error("azimuth out of range");

  // elevation stays within a quarter turn either way
  a_elevation_range: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (cone_elevation <= 15'sd11520 && cone_elevation >= -15'sd11520))
    else $error("elevation out of range");
`endif

endmodule

[bench/tb.sv]
// self-checking bench for spin_to_spherical_angles_core
// depends on s2sa_pkg and the core; holds its own cordic angle predictor
`timescale 1ns / 1ps

module tb;

  typedef logic signed [s2sa_pkg::AZ_W-1:0] azimuth_t;
  typedef logic signed [s2sa_pkg::EL_W-1:0] elevation_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } spin_vec_t;

  typedef struct packed {
    azimuth_t   azimuth;
    elevation_t elevation;
    logic       unhandled;
  } cone_angles_t;

  // run shape
  localparam int NUM_RANDOM    = 1750;
  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
  localparam int TAIL_CYCLES   = 100;   // idle cycles at the end of the run, after every owed result is in
  localparam int HOLD_AT       = 500;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_AT      = 1100;  // vectors sent before the sender waits for a drain
  localparam int QUIET_FROM    = 700;   // window with no random idling on either side
  localparam int QUIET_TO      = 1000;
  localparam int IDLE_PERCENT  = 17;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic signed [15:0] spin_x = '0;
  logic signed [15:0] spin_y = '0;
  logic signed [15:0] spin_z = '0;
  logic             empty;
  logic             pop = 1'b0;
  azimuth_t         cone_azimuth;
  elevation_t       cone_elevation;
  logic             unhandled;

  spin_to_spherical_angles_core dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .spin_x         (spin_x),
    .spin_y         (spin_y),
    .spin_z         (spin_z),
    .empty          (empty),
    .pop            (pop),
    .cone_azimuth   (cone_azimuth),
    .cone_elevation (cone_elevation),
    .unhandled      (unhandled)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // vectors still to be offered, and angles still owed by the core
  spin_vec_t    spin_backlog[$];
  cone_angles_t owed_angles[$];

  // angles the predictor repeats when a component is zero
  azimuth_t   last_azimuth   = '0;
  elevation_t last_elevation = '0;

  int mismatches   = 0;
  int vecs_sent    = 0;
  int angles_seen  = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", angles_seen, what, got, want);
    mismatches++;
  endtask

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  function automatic longint atan_step_fine(input int i);
    case (i)
      0:  return 2949120;
      1:  return 1740967;
      2:  return 919879;
      3:  return 466945;
      4:  return 234379;
      5:  return 117304;
      6:  return 58666;
      7:  return 29335;
      8:  return 14668;
      9:  return 7334;
      10: return 3667;
      11: return 1833;
      12: return 917;
      13: return 458;
      14: return 229;
      15: return 115;
      16: return 57;
      17: return 29;
      18: return 14;
      19: return 7;
      20: return 4;
      21: return 2;
      22: return 1;
      default: return 0;
    endcase
  endfunction

  // vectoring pass on a first-quadrant vector: angle in 1/128 degree, gained length out
  function automatic longint cordic_vector_angle(input longint x_in, input longint y_in,
                                                 output longint gained_len);
    longint x, y, acc, dx, dy;
    int     steps;
    x = x_in;
    y = y_in;
    acc = 0;
    steps = (s2sa_pkg::CORDIC_STEPS > s2sa_pkg::ANG_TABLE_LEN) ?
            s2sa_pkg::ANG_TABLE_LEN : s2sa_pkg::CORDIC_STEPS;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;   // arithmetic shift, rounds toward minus infinity
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        acc += atan_step_fine(i);
      end else begin
        x = x - dx;
        y = y + dy;
        acc -= atan_step_fine(i);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > s2sa_pkg::QUARTER_FINE) acc = s2sa_pkg::QUARTER_FINE;
    gained_len = x;
    return (acc + 256) >>> 9;
  endfunction

  // expected cone angles for one vector; updates the held angles in order of transfer
  function automatic cone_angles_t predict_cone_angles(input spin_vec_t v);
    longint x, y, z, ax, ay, az, len, r, a, t, phi, theta, unused;
    cone_angles_t res;
    x = v.x;
    y = v.y;
    z = v.z;
    if (x == 0 || y == 0 || z == 0) begin
      // zero component: no rule, so the last angles repeat and the flag goes up
      res.azimuth   = last_azimuth;
      res.elevation = last_elevation;
      res.unhandled = 1'b1;
      return res;
    end
    ax = (x < 0 ? -x : x) <<< s2sa_pkg::PRE_SH;
    ay = (y < 0 ? -y : y) <<< s2sa_pkg::PRE_SH;
    az = (z < 0 ? -z : z) <<< s2sa_pkg::PRE_SH;

    a = cordic_vector_angle(ax, ay, len);
    if (x > 0 && y > 0)      phi = a;
    else if (x < 0 && y > 0) phi = s2sa_pkg::HALF_128 - a;
    else if (x < 0)          phi = s2sa_pkg::HALF_128 + a;
    else                     phi = s2sa_pkg::FULL_128 - a;
    if (phi >= s2sa_pkg::FULL_128) phi -= s2sa_pkg::FULL_128;   // 360 degrees wraps to 0

    // strip the cordic gain, round half up
    r = (len * longint'(s2sa_pkg::INV_GAIN_Q30) + (longint'(1) << 29)) >>> s2sa_pkg::GAIN_SH;
    if (r < 1) r = 1;
    t = cordic_vector_angle(r, az, unused);
    if (t > s2sa_pkg::QUARTER_128) t = s2sa_pkg::QUARTER_128;
    theta = (z > 0) ? t : -t;

    last_azimuth   = azimuth_t'(-phi);
    last_elevation = elevation_t'(-theta);
    res.azimuth   = last_azimuth;
    res.elevation = last_elevation;
    res.unhandled = 1'b0;
    return res;
  endfunction

  // one random component: mostly full range, some tiny magnitudes, some extremes
  function automatic logic signed [15:0] random_component(input bit nonzero);
    logic signed [15:0] c;
    case ($urandom_range(9))
      0, 1: begin
        c = 16'($urandom_range(16));
        if ($urandom_range(1)) c = -c;
      end
      2: c = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: c = 16'($urandom());
    endcase
    if (nonzero && c == 0) c = $urandom_range(1) ? 16'sd1 : -16'sd1;
    return c;
  endfunction

  task automatic add_vec(input logic signed [15:0] x, input logic signed [15:0] y,
                         input logic signed [15:0] z);
    spin_vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    spin_backlog = {spin_backlog, v};
  endtask

  // stimulus, reset and the end of the run
  initial begin
    int zero_slot;
    // zero component straight after reset: the held angles must read as zero
    add_vec(16'sd0, 16'sd1, 16'sd1);
    // extremes of every field
    add_vec(16'sh7fff, 16'sh7fff, 16'sh7fff);
    add_vec(16'sh8000, 16'sh8000, 16'sh8000);
    add_vec(16'sh7fff, 16'sh8000, 16'sd1);
    add_vec(16'sh8000, 16'sh7fff, -16'sd1);
    add_vec(16'sd1, 16'sd1, 16'sd1);
    add_vec(-16'sd1, -16'sd1, -16'sd1);
    // zero in each component, then all zero
    add_vec(16'sd0, 16'sd500, 16'sd500);
    add_vec(16'sd500, 16'sd0, 16'sd500);
    add_vec(16'sd500, 16'sd500, 16'sd0);
    add_vec(16'sd0, 16'sd0, 16'sd0);
    // one vector in each quadrant, both signs of z
    add_vec(16'sd1000, 16'sd1000, 16'sd1000);
    add_vec(-16'sd1000, 16'sd1000, -16'sd1000);
    add_vec(-16'sd1000, -16'sd1000, 16'sd1000);
    add_vec(16'sd1000, -16'sd1000, -16'sd1000);
    // near the axes: just above 0, just below 360 (wraps), near 180 and 90
    add_vec(16'sh7fff, 16'sd1, 16'sd1);
    add_vec(16'sh7fff, -16'sd1, 16'sd1);
    add_vec(16'sh8000, 16'sd1, 16'sd1);
    add_vec(16'sh8000, -16'sd1, -16'sd1);
    add_vec(16'sd1, 16'sh7fff, 16'sd1);
    // elevation close to +-90 degrees and close to 0
    add_vec(16'sd1, 16'sd1, 16'sh7fff);
    add_vec(-16'sd1, 16'sd1, 16'sh8000);
    add_vec(16'sh7fff, 16'sh7fff, 16'sd1);
    add_vec(16'sh8000, 16'sh8000, -16'sd1);

    // random part: about one vector in twelve carries a zero component
    repeat (NUM_RANDOM) begin
      zero_slot = ($urandom_range(99) < 8) ? $urandom_range(2) : 3;
      add_vec(zero_slot == 0 ? 16'sd0 : random_component(1'b1),
              zero_slot == 1 ? 16'sd0 : random_component(1'b1),
              zero_slot == 2 ? 16'sd0 : random_component(1'b1));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (spin_backlog.size() != 0 || push) @(posedge clk);
    while (owed_angles.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_angles.size() != 0) begin
      $display("%0d results never arrived", owed_angles.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS spin_to_spherical_angles_core");
    end else begin
      $display("FAIL spin_to_spherical_angles_core");
    end
    $finish;
  end

  // sender: offers vectors from the backlog, idles at random, waits once for a full drain
  bit drain_wait = 1'b0;
  bit drain_used = 1'b0;

  always @(posedge clk) begin
    bit         taken;
    bit         idle;
    logic       next_push;
    spin_vec_t  next_vec;
    if (rst) begin
      push <= 1'b0;
    end else begin
      taken = push && !full;
      if (taken) begin
        next_vec = spin_backlog.pop_front();
        owed_angles = {owed_angles, predict_cone_angles(next_vec)};
        vecs_sent++;
        if (!drain_used && vecs_sent == DRAIN_AT) begin
          drain_used = 1'b1;
          drain_wait = 1'b1;
        end
      end
      if (drain_wait && owed_angles.size() == 0) drain_wait = 1'b0;
      next_push = push;
      if (!push || taken) begin
        idle = (vecs_sent >= QUIET_FROM && vecs_sent < QUIET_TO) ? 1'b0 :
               ($urandom_range(99) < IDLE_PERCENT);
        next_push = (spin_backlog.size() != 0) && !idle && !drain_wait;
        if (next_push) begin
          next_vec = spin_backlog[0];
          spin_x <= next_vec.x;
          spin_y <= next_vec.y;
          spin_z <= next_vec.z;
        end
      end
      push <= next_push;
    end
  end

  // receiver: checks each popped result against the oldest owed angles
  int hold_left = 0;
  bit hold_used = 1'b0;

  always @(posedge clk) begin
    cone_angles_t want;
    bit           idle;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (owed_angles.size() == 0) begin
          report_mismatch("result with nothing owed, cone_azimuth", cone_azimuth, 0);
        end else begin
          want = owed_angles.pop_front();
          if (cone_azimuth !== want.azimuth)
            report_mismatch("cone_azimuth", cone_azimuth, want.azimuth);
          if (cone_elevation !== want.elevation)
            report_mismatch("cone_elevation", cone_elevation, want.elevation);
          if (unhandled !== want.unhandled)
            report_mismatch("unhandled", unhandled, want.unhandled);
        end
        angles_seen++;
      end
      // one long hold-off so the queue fills and full back-pressures the sender
      if (!hold_used && angles_seen >= HOLD_AT) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        idle = (angles_seen >= QUIET_FROM && angles_seen < QUIET_TO) ? 1'b0 :
               ($urandom_range(99) < IDLE_PERCENT);
        pop <= !idle;
      end
    end
  end

  // watchdog: too long without a transfer on either side means the core is stuck
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", quiet_cycles);
      $display("FAIL spin_to_spherical_angles_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[sim.f]
hw/rtl/s2sa_pkg.sv
hw/rtl/s2sa_front.sv
hw/rtl/s2sa_queue.sv
hw/rtl/s2sa_cordic.sv
hw/rtl/s2sa_back.sv
hw/rtl/spin_to_spherical_angles_core.sv
bench/tb.sv
